@@ design/cst_pkg.sv @@
// Shared types and constants for the completion scoreboard table.
// Used by the front, queue, back, top level and checker; no dependencies.
`default_nettype none

package cst_pkg;

   localparam int SLOT_W      = 4;
   localparam int DEV_W       = 16;
   localparam int COUNT_W     = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_LOOKUP   = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUT_PENDING = 2'd0,
      OUT_CLEAN   = 2'd1,
      OUT_SEVERE  = 2'd2,
      OUT_IDLE    = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      KIND_ALLOC,
      KIND_COMPLETE,
      KIND_LOOKUP,
      KIND_IDLE_ERR,
      KIND_NONE
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      kind_type             kind;
      logic [DEV_W-1:0]     device_id;
      logic [COUNT_W-1:0]   needed_count;
      logic [SLOT_W-1:0]    slot;
      logic                 severe;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   severe_count;
      logic [COUNT_W-1:0]   pending_count;
      logic [DEV_W-1:0]     device_id;
   } entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot_index;
      logic                 table_full;
      outcome_type          outcome;
      logic [DEV_W-1:0]     stored_device;
      logic                 free_available;
   } result_type;

endpackage

`default_nettype wire

@@ design/cst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/cst_front.sv @@
// Front end: accepts request words and classifies them into commands.
// Depends on cst_pkg.
`default_nettype none

module cst_front #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [cst_pkg::DEV_W-1:0]     req_device_id,
   input  wire logic [cst_pkg::COUNT_W-1:0]   req_needed_count,
   input  wire logic [cst_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic                          req_severe,
   output      logic                          push_valid,
   input  wire logic                          push_stall,
   output      cst_pkg::cmd_type              push_cmd
);
   import cst_pkg::*;

   localparam int ADDR_SLOTS = (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);

   logic in_range;

   assign in_range   = {1'b0, req_slot} < (SLOT_W + 1)'(ADDR_SLOTS);
   assign push_valid = req_valid;
   assign req_stall  = push_stall;

   always_comb begin
      push_cmd.device_id    = req_device_id;
      push_cmd.needed_count = req_needed_count;
      push_cmd.slot         = req_slot;
      push_cmd.severe       = req_severe;
      unique case (op_type'(req_operation))
         OP_ALLOC:    push_cmd.kind = KIND_ALLOC;
         OP_COMPLETE: push_cmd.kind = in_range ? KIND_COMPLETE : KIND_IDLE_ERR;
         OP_LOOKUP:   push_cmd.kind = in_range ? KIND_LOOKUP : KIND_NONE;
         default:     push_cmd.kind = KIND_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ design/cst_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on cst_pkg.
`default_nettype none

module cst_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             push_stall,
   input  wire cst_pkg::cmd_type push_cmd,
   output      logic             pop_valid,
   input  wire logic             pop,
   output      cst_pkg::cmd_type pop_cmd
);
   import cst_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_stall = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop && pop_valid;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ design/cst_back.sv @@
// Back end: slot table (RAM plus free bitmap), allocation encoder and result register.
// Depends on cst_pkg and cst_ram.
`default_nettype none

module cst_back #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_valid,
   input  wire cst_pkg::cmd_type    cmd_head,
   output      logic                cmd_pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      cst_pkg::result_type rsp_result
);
   import cst_pkg::*;

   localparam int ADDR_SLOTS = (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);
   localparam int IDX_W      = (ADDR_SLOTS > 1) ? $clog2(ADDR_SLOTS) : 1;
   localparam int ENTRY_W    = $bits(entry_type);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IDX_W-1:0]      grant_ff, grant_in;
   logic                  full_ff, full_in;
   logic [ADDR_SLOTS-1:0] free_ff, free_in, free_next;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in, result;

   logic [IDX_W-1:0]      grant;
   logic                  grant_found;
   logic                  out_room;
   logic                  exec_fire;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      idx;
   logic [ENTRY_W-1:0]    rd_data;
   entry_type             entry;
   entry_type             wr_entry;
   logic                  wr_en;
   logic [COUNT_W-1:0]    pend_dec;
   logic [COUNT_W-1:0]    sev_next;

   cst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ADDR_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // lowest free slot
   always_comb begin
      grant = '0;
      for (int i = ADDR_SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            grant = IDX_W'(i);
         end
      end
   end
   assign grant_found = |free_ff;

   assign out_room = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (cmd_valid) begin
            state_in = BK_EXEC;
         end
         BK_EXEC: if (out_room) begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = (state_ff == BK_IDLE) && cmd_valid;
      rd_en     = cmd_pop;
      exec_fire = (state_ff == BK_EXEC) && out_room;
   end

   assign rd_addr  = (cmd_head.kind == KIND_ALLOC) ? grant : cmd_head.slot[IDX_W-1:0];
   assign cmd_in   = cmd_pop ? cmd_head : cmd_ff;
   assign grant_in = cmd_pop ? grant : grant_ff;
   assign full_in  = cmd_pop ? !grant_found : full_ff;

   assign idx   = (cmd_ff.kind == KIND_ALLOC) ? grant_ff : cmd_ff.slot[IDX_W-1:0];
   assign entry = entry_type'(rd_data);

   assign pend_dec = entry.pending_count - 1'b1;
   assign sev_next = (cmd_ff.severe && entry.severe_count != COUNT_MAX) ?
                     entry.severe_count + 1'b1 : entry.severe_count;

   always_comb begin
      result.slot_index     = cmd_ff.slot;
      result.table_full     = 1'b0;
      result.outcome        = OUT_PENDING;
      result.stored_device  = '0;
      wr_en                 = 1'b0;
      wr_entry              = entry;
      free_next             = free_ff;
      unique case (cmd_ff.kind)
         KIND_ALLOC: begin
            if (full_ff) begin
               result.slot_index = '0;
               result.table_full = 1'b1;
            end else begin
               wr_entry.device_id     = cmd_ff.device_id;
               wr_entry.pending_count = cmd_ff.needed_count;
               wr_entry.severe_count  = '0;
               wr_en                  = exec_fire;
               free_next[idx]         = cmd_ff.needed_count == '0;
               result.slot_index      = SLOT_W'(grant_ff);
               result.stored_device   = cmd_ff.device_id;
            end
         end
         KIND_COMPLETE: begin
            result.stored_device = entry.device_id;
            if (free_ff[idx]) begin
               result.outcome = OUT_IDLE;
            end else begin
               wr_entry.pending_count = pend_dec;
               wr_entry.severe_count  = sev_next;
               wr_en                  = exec_fire;
               if (pend_dec == '0) begin
                  free_next[idx] = 1'b1;
                  result.outcome = (sev_next == '0) ? OUT_CLEAN : OUT_SEVERE;
               end
            end
         end
         KIND_LOOKUP:   result.stored_device = entry.device_id;
         KIND_IDLE_ERR: result.outcome = OUT_IDLE;
         default:       result.outcome = OUT_PENDING;
      endcase
      result.free_available = |free_next;
   end

   assign free_in      = exec_fire ? free_next : free_ff;
   assign rsp_in       = exec_fire ? result : rsp_ff;
   assign rsp_valid_in = exec_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      grant_ff <= grant_in;
      full_ff  <= full_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

`default_nettype wire

@@ design/completion_scoreboard_table.sv @@
// Completion scoreboard table: top level tying front end, queue and back end.
// Depends on cst_pkg, cst_front, cst_queue and cst_back.
//
// Usage:
//   req_* carries one request word: allocate a slot, retire one result of a
//   slot, or look up a slot's device id. rsp_* returns exactly one result
//   word per request, in request order.
//   A word moves on a channel at a rising edge with valid high and stall low.
//   An accepted request is written into the command queue, popped into the
//   back end with its slot RAM read, and written to the result register once
//   the result side has room. The back end takes no new request until the
//   current one is through the slot RAM read-modify-write (read, then update).
//   The two-entry command queue takes new requests while the back end works
//   or while a finished result waits in the output register.
//   Reset (synchronous, active high) empties the queue and the result
//   register and marks every slot free; device ids read back from slots never
//   allocated are undefined.
//   A stalled result holds its word; the back end then stops, the queue fills
//   and req_stall rises.
`default_nettype none

module completion_scoreboard_table #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [cst_pkg::DEV_W-1:0]     req_device_id,
   input  wire logic [cst_pkg::COUNT_W-1:0]   req_needed_count,
   input  wire logic [cst_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic                          req_severe,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [cst_pkg::SLOT_W-1:0]    rsp_slot_index,
   output      logic                          rsp_table_full,
   output      logic [1:0]                    rsp_outcome,
   output      logic [cst_pkg::DEV_W-1:0]     rsp_stored_device,
   output      logic                          rsp_free_available
);
   import cst_pkg::*;

   logic       push_valid;
   logic       push_stall;
   cmd_type    push_cmd;
   logic       pop_valid;
   logic       pop;
   cmd_type    pop_cmd;
   result_type rsp_result;

   cst_front #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_device_id    (req_device_id),
      .req_needed_count (req_needed_count),
      .req_slot         (req_slot),
      .req_severe       (req_severe),
      .push_valid       (push_valid),
      .push_stall       (push_stall),
      .push_cmd         (push_cmd)
   );

   cst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   cst_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_head   (pop_cmd),
      .cmd_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_slot_index     = rsp_result.slot_index;
   assign rsp_table_full     = rsp_result.table_full;
   assign rsp_outcome        = rsp_result.outcome;
   assign rsp_stored_device  = rsp_result.stored_device;
   assign rsp_free_available = rsp_result.free_available;

endmodule

`default_nettype wire

@@ design/cst_checker.sv @@
// Port-level checks for completion_scoreboard_table, bound to the top level.
// Depends on cst_pkg and completion_scoreboard_table.
`default_nettype none

module cst_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [cst_pkg::SLOT_W-1:0]    rsp_slot_index,
   input wire logic                          rsp_table_full,
   input wire logic [1:0]                    rsp_outcome,
   input wire logic [cst_pkg::DEV_W-1:0]     rsp_stored_device,
   input wire logic                          rsp_free_available
);
   import cst_pkg::*;

   a_full_word_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |->
         rsp_slot_index == '0 && rsp_outcome == OUT_PENDING && rsp_stored_device == '0)
      else $error("full word carries slot, outcome or device");

   a_full_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_free_available)
      else $error("full table reports a free slot");

   a_done_frees_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_CLEAN || rsp_outcome == OUT_SEVERE) |->
         rsp_free_available && !rsp_table_full)
      else $error("finished request left no free slot");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_slot_index) && $stable(rsp_outcome) &&
         $stable(rsp_stored_device) && $stable(rsp_free_available))
      else $error("stalled result word changed");

endmodule

bind completion_scoreboard_table cst_checker u_checker (.*);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for completion_scoreboard_table: directed and random request words.
// A slot-table predictor supplies the expected result words. Depends on cst_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
   import cst_pkg::*;

   localparam int SLOTS = 16;
   localparam int PLAN  = 0;
   localparam int SCORE = 1;

   typedef struct {
      op_type                op;
      logic [DEV_W-1:0]      dev;
      logic [COUNT_W-1:0]    need;
      logic [SLOT_W-1:0]     slot;
      logic                  sev;
      bit                    hold;
   } req_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_operation = OP_NOP;
   logic [DEV_W-1:0]      req_device_id = '0;
   logic [COUNT_W-1:0]    req_needed_count = '0;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic                  req_severe = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic                  rsp_table_full;
   logic [1:0]            rsp_outcome;
   logic [DEV_W-1:0]      rsp_stored_device;
   logic                  rsp_free_available;

   // slot tables: one copy for planning stimulus, one for scoring results
   logic [COUNT_W-1:0]    pend_cnt [2][SLOTS];
   logic [DEV_W-1:0]      dev_tab  [2][SLOTS];
   logic [COUNT_W-1:0]    sev_cnt  [2][SLOTS];
   bit   [SLOTS-1:0]      ever_alloc = '0;

   req_word_type          req_words [$];
   result_type            awaited [$];
   logic                  req_taken = 1'b0;
   int                    failures = 0;
   int                    burst_left = 1;
   int                    gap_left = 0;
   int                    stall_mode = 0;
   int                    stall_cyc = 0;

   completion_scoreboard_table #(.SLOT_COUNT(SLOTS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_device_id      (req_device_id),
      .req_needed_count   (req_needed_count),
      .req_slot           (req_slot),
      .req_severe         (req_severe),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_table_full     (rsp_table_full),
      .rsp_outcome        (rsp_outcome),
      .rsp_stored_device  (rsp_stored_device),
      .rsp_free_available (rsp_free_available)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int first_free(input int side);
      for (int i = 0; i < SLOTS; i++) begin
         if (pend_cnt[side][i] == '0) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic result_type table_step(input int side, input req_word_type w);
      result_type r;
      int f;
      r.slot_index = w.slot;
      r.table_full = 1'b0;
      r.outcome = OUT_PENDING;
      r.stored_device = '0;
      case (w.op)
         OP_ALLOC: begin
            f = first_free(side);
            if (f < 0) begin
               r.table_full = 1'b1;
               r.slot_index = '0;
            end else begin
               dev_tab[side][f] = w.dev;
               pend_cnt[side][f] = w.need;
               sev_cnt[side][f] = '0;
               r.slot_index = SLOT_W'(f);
               r.stored_device = w.dev;
            end
         end
         OP_COMPLETE: begin
            r.stored_device = dev_tab[side][w.slot];
            if (pend_cnt[side][w.slot] == '0) begin
               r.outcome = OUT_IDLE;
            end else begin
               pend_cnt[side][w.slot] = pend_cnt[side][w.slot] - 1'b1;
               if (w.sev && sev_cnt[side][w.slot] != COUNT_MAX) begin
                  sev_cnt[side][w.slot] = sev_cnt[side][w.slot] + 1'b1;
               end
               if (pend_cnt[side][w.slot] != '0) begin
                  r.outcome = OUT_PENDING;
               end else if (sev_cnt[side][w.slot] == '0) begin
                  r.outcome = OUT_CLEAN;
               end else begin
                  r.outcome = OUT_SEVERE;
               end
            end
         end
         OP_LOOKUP: begin
            r.stored_device = dev_tab[side][w.slot];
         end
         default: ;
      endcase
      r.free_available = (first_free(side) >= 0);
      return r;
   endfunction

   task automatic queue_word(input op_type op, input logic [DEV_W-1:0] dev,
                             input logic [COUNT_W-1:0] need, input logic [SLOT_W-1:0] slot,
                             input logic sev, input bit hold);
      req_word_type w;
      result_type r;
      w.op = op;
      w.dev = dev;
      w.need = need;
      w.slot = slot;
      w.sev = sev;
      w.hold = hold;
      r = table_step(PLAN, w);
      if (op == OP_ALLOC && !r.table_full) begin
         ever_alloc[r.slot_index] = 1'b1;
      end
      req_words.push_back(w);
   endtask

   function automatic logic [SLOT_W-1:0] written_slot();
      logic [SLOT_W-1:0] s;
      do begin
         s = SLOT_W'($urandom);
      end while (!ever_alloc[s]);
      return s;
   endfunction

   task automatic check_field(input string name, input logic [DEV_W-1:0] want,
                              input logic [DEV_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // driver: advance to the next word once the current one is taken
   always @(negedge clock) begin : drive
      req_word_type w;
      logic nv;
      nv = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         nv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (req_words.size() != 0 &&
                      !(req_words[0].hold && awaited.size() != 0)) begin
            w = req_words.pop_front();
            req_operation <= w.op;
            req_device_id <= w.dev;
            req_needed_count <= w.need;
            req_slot <= w.slot;
            req_severe <= w.sev;
            nv = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
      req_valid <= nv;
   end

   always @(negedge clock) begin : stall_pattern
      logic ns;
      stall_cyc++;
      if (stall_cyc % 150 == 0) begin
         stall_mode = $urandom_range(0, 2);
      end
      case (stall_mode)
         1: ns = ($urandom_range(0, 2) == 0);
         2: ns = ((stall_cyc % 7) < 4);
         default: ns = 1'b0;
      endcase
      rsp_stall <= reset ? 1'b0 : ns;
   end

   always @(posedge clock) begin : watch
      req_word_type w;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            w.op = op_type'(req_operation);
            w.dev = req_device_id;
            w.need = req_needed_count;
            w.slot = req_slot;
            w.sev = req_severe;
            w.hold = 1'b0;
            awaited.push_back(table_step(SCORE, w));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $error("result word with nothing expected");
               failures++;
            end else begin
               want = awaited.pop_front();
               check_field("slot_index", DEV_W'(want.slot_index), DEV_W'(rsp_slot_index));
               check_field("table_full", DEV_W'(want.table_full), DEV_W'(rsp_table_full));
               check_field("outcome", DEV_W'(want.outcome), DEV_W'(rsp_outcome));
               check_field("stored_device", want.stored_device, rsp_stored_device);
               check_field("free_available", DEV_W'(want.free_available),
                           DEV_W'(rsp_free_available));
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int g;
      int r;
      int pick;
      int cand [$];
      bit hold;
      logic [COUNT_W-1:0] need;
      logic [SLOT_W-1:0] s;
      for (int i = 0; i < SLOTS; i++) begin
         for (int k = 0; k < 2; k++) begin
            pend_cnt[k][i] = '0;
            dev_tab[k][i] = '0;
            sev_cnt[k][i] = '0;
         end
      end

      // directed: fill the table, overflow it, then finish slots clean and severe
      queue_word(OP_NOP, 16'hFFFF, 8'hFF, 4'hF, 1'b1, 1'b0);
      for (int i = 0; i < SLOTS; i++) begin
         queue_word(OP_ALLOC, (i == 0) ? 16'h0000 : (i == SLOTS - 1) ? 16'hFFFF : 16'($urandom),
                    (i == 0) ? 8'd1 : 8'd2, SLOT_W'($urandom), 1'($urandom), 1'b0);
      end
      queue_word(OP_ALLOC, 16'hA5A5, 8'd3, 4'h0, 1'b0, 1'b0);
      queue_word(OP_COMPLETE, 16'h0, 8'h0, 4'd0, 1'b0, 1'b1);
      queue_word(OP_COMPLETE, 16'h0, 8'h0, 4'd0, 1'b1, 1'b0);
      queue_word(OP_ALLOC, 16'h1234, 8'd0, 4'hF, 1'b0, 1'b0);
      queue_word(OP_COMPLETE, 16'hFFFF, 8'hFF, 4'd2, 1'b1, 1'b0);
      queue_word(OP_COMPLETE, 16'hFFFF, 8'hFF, 4'd2, 1'b0, 1'b0);
      queue_word(OP_LOOKUP, 16'h0, 8'h0, 4'd15, 1'b0, 1'b0);
      queue_word(OP_LOOKUP, 16'h0, 8'h0, 4'd0, 1'b0, 1'b0);
      queue_word(OP_COMPLETE, 16'h0, 8'h0, 4'd3, 1'b0, 1'b0);
      queue_word(OP_COMPLETE, 16'h0, 8'h0, 4'd3, 1'b0, 1'b0);

      // one request awaiting the most results, every one severe
      g = first_free(PLAN);
      if (g >= 0) begin
         queue_word(OP_ALLOC, 16'($urandom), 8'hFF, 4'h0, 1'b0, 1'b0);
         for (int i = 0; i < 255; i++) begin
            queue_word(OP_COMPLETE, 16'($urandom), 8'($urandom), SLOT_W'(g), 1'b1, 1'b0);
         end
      end

      for (int n = 0; n < 850; n++) begin
         r = $urandom_range(0, 99);
         hold = ($urandom_range(0, 199) == 0);
         if (r < 35) begin
            pick = $urandom_range(0, 99);
            need = (pick < 8) ? 8'd0 :
                   (pick < 16) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 4));
            queue_word(OP_ALLOC, 16'($urandom), need, SLOT_W'($urandom), 1'($urandom), hold);
         end else if (r < 80) begin
            cand.delete();
            for (int i = 0; i < SLOTS; i++) begin
               if (pend_cnt[PLAN][i] != '0) begin
                  cand.push_back(i);
               end
            end
            if (cand.size() != 0 && $urandom_range(0, 99) < 85) begin
               s = SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
            end else begin
               s = written_slot();
            end
            queue_word(OP_COMPLETE, 16'($urandom), 8'($urandom), s,
                       ($urandom_range(0, 3) == 0), hold);
         end else if (r < 95) begin
            queue_word(OP_LOOKUP, 16'($urandom), 8'($urandom), written_slot(),
                       1'($urandom), hold);
         end else begin
            queue_word(OP_NOP, 16'($urandom), 8'($urandom), SLOT_W'($urandom),
                       1'($urandom), hold);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (req_words.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
